FILE: hdl/tcw_pkg.sv
// Shared constants, codes and transaction types of the text console writer.
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int CELL_IDX_W = 11;
   localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] BLANK_ATTR     = 8'h0F;
   localparam logic [15:0] BLANK_CELL    = {BLANK_ATTR, CHAR_SPACE};

   // Cursor unit commands
   localparam logic [2:0] CUR_HOLD    = 3'd0;
   localparam logic [2:0] CUR_NEWLINE = 3'd1;
   localparam logic [2:0] CUR_BACK    = 3'd2;
   localparam logic [2:0] CUR_ADVANCE = 3'd3;
   localparam logic [2:0] CUR_HOME    = 3'd4;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [7:0]            char_code;
      logic [7:0]            attribute;
      logic [CELL_IDX_W-1:0] read_index;
   } tcw_req_type;

   typedef struct packed {
      logic [7:0]            cell_char;
      logic [7:0]            cell_attr;
      logic [CELL_IDX_W-1:0] cursor_position;
      logic                  scrolled;
   } tcw_rsp_type;

   typedef struct packed {
      logic [CELL_IDX_W-1:0] cursor;
      logic                  last_row;
      logic                  last_col;
      logic                  at_origin;
   } tcw_cur_stat_type;

endpackage

FILE: hdl/text_mode_console_writer.sv
// Top level of the text console writer: screen store and sequencer.
//
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with rsp_valid, and the receiver cannot
// stall it. The screen store has one read and one write port and moves one
// cell per cycle. A plain put, backspace or newline, an unused opcode and a
// read past the last cell give their result straight from ST_EXEC; a read
// passes ST_READ first. A put or newline that scrolls the screen runs ST_COPY
// (copy every row up) and then ST_BLANK on the bottom row, and a clear runs
// ST_BLANK over the whole store. After reset the block blanks the whole
// store, one cell per cycle, with busy high. busy drops in the cycle the
// result is shown, so the next transaction may be taken then.
module text_mode_console_writer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcw_pkg::tcw_req_type req_item,
   output logic                 rsp_valid,
   output tcw_pkg::tcw_rsp_type rsp_item
);
   import tcw_pkg::*;

   localparam logic [2:0] ST_BLANK = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   logic [15:0] screen_mem [CELL_COUNT];

   logic [2:0]            state_ff, state_in;
   tcw_req_type           req_ff, req_in;
   logic [CELL_IDX_W-1:0] sweep_ff, sweep_in;
   logic [CELL_IDX_W-1:0] dst_ff, dst_in;
   logic                  copy_pend_ff, copy_pend_in;
   logic                  notify_ff, notify_in;
   logic                  scroll_ff, scroll_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           cell_ff, cell_in;
   logic [15:0]           rd_data_ff;

   logic                  mem_we, mem_re;
   logic [CELL_IDX_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]           mem_wdata;
   logic                  copy_issue;

   logic [2:0]            cur_cmd;
   tcw_cur_stat_type      cur_stat;

   tcw_cursor u_cursor (
      .clock (clock),
      .reset (reset),
      .cmd   (cur_cmd),
      .stat  (cur_stat)
   );

   assign copy_issue = (sweep_ff < CELL_IDX_W'(CELL_COUNT - COLUMNS));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      sweep_in     = sweep_ff;
      dst_in       = dst_ff;
      copy_pend_in = 1'b0;
      notify_in    = notify_ff;
      scroll_in    = scroll_ff;
      rsp_valid_in = 1'b0;
      cell_in      = cell_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = BLANK_CELL;
      mem_re       = 1'b0;
      mem_raddr    = req_ff.read_index;
      cur_cmd      = CUR_HOLD;

      case (state_ff)
         ST_BLANK: begin
            mem_we = 1'b1;
            if (sweep_ff == CELL_IDX_W'(CELL_COUNT - 1)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = notify_ff;
               notify_in    = 1'b0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            scroll_in = 1'b0;
            cell_in   = '0;
            sweep_in  = '0;
            state_in  = ST_IDLE;
            case (req_ff.opcode)
               OP_PUT: begin
                  if (req_ff.char_code == CHAR_NEWLINE) begin
                     cur_cmd = CUR_NEWLINE;
                     if (cur_stat.last_row) begin
                        scroll_in = 1'b1;
                        state_in  = ST_COPY;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end else if (req_ff.char_code == CHAR_BACKSPACE &&
                               !cur_stat.at_origin) begin
                     cur_cmd      = CUR_BACK;
                     mem_we       = 1'b1;
                     mem_waddr    = cur_stat.cursor - 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     cur_cmd   = CUR_ADVANCE;
                     mem_we    = 1'b1;
                     mem_waddr = cur_stat.cursor;
                     mem_wdata = {req_ff.attribute, req_ff.char_code};
                     if (cur_stat.last_row && cur_stat.last_col) begin
                        scroll_in = 1'b1;
                        state_in  = ST_COPY;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               end
               OP_CLEAR: begin
                  cur_cmd   = CUR_HOME;
                  notify_in = 1'b1;
                  state_in  = ST_BLANK;
               end
               OP_READ: begin
                  if (req_ff.read_index < CELL_IDX_W'(CELL_COUNT)) begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_COPY: begin
            // read one row ahead, write the previous read back one row up
            mem_raddr = sweep_ff + CELL_IDX_W'(COLUMNS);
            mem_we    = copy_pend_ff;
            mem_waddr = dst_ff;
            mem_wdata = rd_data_ff;
            dst_in    = sweep_ff;
            if (copy_issue) begin
               mem_re       = 1'b1;
               copy_pend_in = 1'b1;
               sweep_in     = sweep_ff + 1'b1;
            end else begin
               // last pending copy lands this cycle; blank the bottom row next
               notify_in = 1'b1;
               state_in  = ST_BLANK;
            end
         end
         ST_READ: begin
            cell_in      = rd_data_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BLANK;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         notify_ff    <= 1'b0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         notify_ff    <= notify_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      dst_ff  <= dst_in;
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign rsp_item.cell_char       = cell_ff[7:0];
   assign rsp_item.cell_attr       = cell_ff[15:8];
   assign rsp_item.cursor_position = cur_stat.cursor;
   assign rsp_item.scrolled        = scroll_ff;

endmodule

FILE: hdl/tcw_cursor.sv
// Cursor unit: linear cursor kept alongside its row and column.
module tcw_cursor (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                cmd,
   output tcw_pkg::tcw_cur_stat_type stat
);
   import tcw_pkg::*;

   logic [CELL_IDX_W-1:0] cursor_ff, cursor_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  last_row, last_col;

   assign last_row = (row_ff == ROW_W'(ROWS - 1));
   assign last_col = (col_ff == COL_W'(COLUMNS - 1));

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      case (cmd)
         CUR_NEWLINE: begin
            col_in = '0;
            if (last_row) begin
               // scroll pulls the cursor back to the bottom row start
               cursor_in = CELL_IDX_W'(CELL_COUNT - COLUMNS);
            end else begin
               cursor_in = cursor_ff + CELL_IDX_W'(COLUMNS) - CELL_IDX_W'(col_ff);
               row_in    = row_ff + 1'b1;
            end
         end
         CUR_BACK: begin
            cursor_in = cursor_ff - 1'b1;
            if (col_ff == '0) begin
               col_in = COL_W'(COLUMNS - 1);
               row_in = row_ff - 1'b1;
            end else begin
               col_in = col_ff - 1'b1;
            end
         end
         CUR_ADVANCE: begin
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  cursor_in = CELL_IDX_W'(CELL_COUNT - COLUMNS);
               end else begin
                  cursor_in = cursor_ff + 1'b1;
                  row_in    = row_ff + 1'b1;
               end
            end else begin
               cursor_in = cursor_ff + 1'b1;
               col_in    = col_ff + 1'b1;
            end
         end
         CUR_HOME: begin
            cursor_in = '0;
            col_in    = '0;
            row_in    = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign stat.cursor    = cursor_ff;
   assign stat.last_row  = last_row;
   assign stat.last_col  = last_col;
   assign stat.at_origin = (cursor_ff == '0);

endmodule
